### rtl/osc_pkg.sv
// osc_pkg: constants and types shared by the ofdm symbol cutter
// no dependencies

`default_nettype none

package osc_pkg;

   localparam int SampleWidth = 16;
   localparam int CountWidth  = 16;
   localparam int SymWidth    = 8;
   localparam int MarkerWidth = 8;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 16;

   // register indexes on the csr port
   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_SYMBOL_LENGTH     = 2'd0,
      CSR_GUARD_LENGTH      = 2'd1,
      CSR_SYMBOLS_PER_FRAME = 2'd2,
      CSR_START_OFFSET      = 2'd3
   } csr_addr_type;

   localparam logic [13:0] SymbolLengthReset    = 14'd2048;
   localparam logic [13:0] GuardLengthReset     = 14'd504;
   localparam logic [7:0]  SymbolsPerFrameReset = 8'd76;
   localparam logic [15:0] StartOffsetReset     = 16'd1;

   localparam logic [MarkerWidth-1:0] FrameMarker = 8'd1;

endpackage : osc_pkg

`default_nettype wire

### rtl/ofdm_symbol_cutter.sv
// ofdm_symbol_cutter: result word registered from the accepted input word,
// throughput one word per cycle, set by the single phase/counter update step
// and the output register, which frees itself whenever rsp_tready is high.
// synchronous active-high reset: phase back to waiting, counters cleared,
// registers to 2048 / 504 / 76 / 1, no result word pending.
// uses osc_pkg

`default_nettype none

module ofdm_symbol_cutter import osc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // csr write port
   input  wire logic                    csr_we,
   input  wire logic [CsrAddrWidth-1:0] csr_addr,
   input  wire logic [CsrDataWidth-1:0] csr_wdata,
   // input samples
   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   input  wire logic [31:0]             req_tdata,   // sample_re [15:0], sample_im [31:16]
   input  wire logic [7:0]              req_tuser,   // start_marker [7:0]
   // passed symbol samples
   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   output      logic [31:0]             rsp_tdata,   // out_re [15:0], out_im [31:16]
   output      logic [0:0]              rsp_tuser    // frame_first [0]
);

   typedef enum logic [1:0] {
      PH_WAIT   = 2'd0,
      PH_OFFSET = 2'd1,
      PH_SYMBOL = 2'd2,
      PH_GUARD  = 2'd3
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] sample_count_ff, sample_count_in;
   logic [SymWidth-1:0]   symbol_count_ff, symbol_count_in;

   logic [13:0] symbol_length_ff;
   logic [13:0] guard_length_ff;
   logic [7:0]  symbols_per_frame_ff;
   logic [15:0] start_offset_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_first_ff;

   logic        accept;
   logic        emit;
   logic        first;
   logic [CountWidth:0] count_p1;
   logic [CountWidth:0] count_p2;
   logic [SymWidth:0]   sym_p1;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_first_ff;

   assign count_p1 = {1'b0, sample_count_ff} + (CountWidth+1)'(1);
   assign count_p2 = {1'b0, sample_count_ff} + (CountWidth+1)'(2);
   assign sym_p1   = {1'b0, symbol_count_ff} + (SymWidth+1)'(1);

   always_comb begin
      phase_in        = phase_ff;
      sample_count_in = sample_count_ff;
      symbol_count_in = symbol_count_ff;
      emit            = 1'b0;
      first           = 1'b0;
      unique case (phase_ff)
         PH_WAIT: begin
            if (req_tuser == FrameMarker) begin
               phase_in = PH_OFFSET;
            end
            sample_count_in = '0;
         end
         PH_OFFSET: begin
            if (count_p1 < {1'b0, start_offset_ff}) begin
               sample_count_in = count_p1[CountWidth-1:0];
            end else begin
               phase_in        = PH_SYMBOL;
               sample_count_in = '0;
            end
         end
         PH_SYMBOL: begin
            if (sample_count_ff < {2'b00, symbol_length_ff}) begin
               emit            = 1'b1;
               first           = (symbol_count_ff == '0) && (sample_count_ff == '0);
               sample_count_in = count_p1[CountWidth-1:0];
            end else begin
               // the word after the symbol is dropped; unless the frame ends, it counts as guard
               sample_count_in = '0;
               if (sym_p1 >= {1'b0, symbols_per_frame_ff}) begin
                  phase_in        = PH_WAIT;
                  symbol_count_in = '0;
               end else begin
                  phase_in        = PH_GUARD;
                  symbol_count_in = sym_p1[SymWidth-1:0];
               end
            end
         end
         PH_GUARD: begin
            if (count_p2 < {3'b000, guard_length_ff}) begin
               sample_count_in = count_p1[CountWidth-1:0];
            end else begin
               phase_in        = PH_SYMBOL;
               sample_count_in = '0;
            end
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff             <= PH_WAIT;
         sample_count_ff      <= '0;
         symbol_count_ff      <= '0;
         rsp_valid_ff         <= 1'b0;
         symbol_length_ff     <= SymbolLengthReset;
         guard_length_ff      <= GuardLengthReset;
         symbols_per_frame_ff <= SymbolsPerFrameReset;
         start_offset_ff      <= StartOffsetReset;
      end else begin
         if (csr_we) begin
            unique case (csr_addr_type'(csr_addr))
               CSR_SYMBOL_LENGTH:     symbol_length_ff     <= csr_wdata[13:0];
               CSR_GUARD_LENGTH:      guard_length_ff      <= csr_wdata[13:0];
               CSR_SYMBOLS_PER_FRAME: symbols_per_frame_ff <= csr_wdata[7:0];
               CSR_START_OFFSET:      start_offset_ff      <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff        <= phase_in;
            sample_count_ff <= sample_count_in;
            symbol_count_ff <= symbol_count_in;
            rsp_valid_ff    <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff    <= 1'b0;
         end
      end
      if (accept && emit) begin
         rsp_data_ff  <= req_tdata;
         rsp_first_ff <= first;
      end
   end

   // a stalled output must be what holds off the input
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled without a pending result word");

   // waiting clears the sample count
   assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_WAIT) |=> sample_count_ff == '0)
      else $error("sample count not cleared while waiting");

   // symbol count stays below the largest frame size
   assert property (@(posedge clock) disable iff (reset)
      symbol_count_ff != {SymWidth{1'b1}})
      else $error("symbol count out of range");

   // frame_first only on the first word of a frame
   assert property (@(posedge clock) disable iff (reset)
      (accept && emit && first) |=> sample_count_ff == CountWidth'(1)
         && symbol_count_ff == '0)
      else $error("frame_first word not at frame start");

endmodule : ofdm_symbol_cutter

`default_nettype wire
